/* rtl/core/gbce_pkg.sv */
// Package for the gap buffer cursor engine: command codes, the newline byte
// and the default store capacity. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbce_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam logic [7:0]  NEWLINE      = 8'd10;
  localparam int unsigned FIELD_W      = 11;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_LEFT      = 3'd2,
    CMD_RIGHT     = 3'd3,
    CMD_DOWN      = 3'd4,
    CMD_UP        = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_MARK      = 3'd7
  } cmd_e;

endpackage
`default_nettype wire

/* rtl/core/gap_buffer_cursor_engine_unit.sv */
// Top level of the gap buffer cursor engine: text store memory, counters and
// the command sequencer. Depends on gbce_pkg.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Contents
// s_axis    in         tdata: cmd[2:0], char_in[10:3], zero pad to 16 bits
// m_axis    out        tdata: char_out, done_res, full_res, cursor_line,
//                      cursor_col, line_count, text_length, is_saved (56 bits)
//
// Insert, clear and mark saved go from the idle state straight to done.
// Every byte crossed or inspected takes an address state and then a data
// state on the single memory read port (S_ISSUE, S_EXEC; S_SCAN, S_SCEX):
// a cursor step crosses one byte, a column recomputation scans back byte by
// byte, and a line move crosses bytes to the target line, then enters S_WALK,
// which starts the column walk and precedes each byte walked along that line.
// Reset clears the counters and flags; the text store is not cleared, since
// only entries already written are ever read.
// A new request is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register.
module gap_buffer_cursor_engine_unit #(
  parameter int unsigned CAPACITY = gbce_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0: cmd[2:0], char_in[10:3], zeros above.
  input  wire logic [15:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // Fields from bit 0: char_out[7:0], done_res[8], full_res[9],
  // cursor_line[20:10], cursor_col[31:21], line_count[42:32],
  // text_length[53:43], is_saved[54], zeros above.
  output logic [55:0]      m_axis_tdata_o
);
  import gbce_pkg::*;

  // Count width holds CAPACITY itself; the line counter holds CAPACITY + 1.
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 2);
  localparam logic [CW-1:0] CAPW = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SCEX  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    OP_BS, OP_LEFT, OP_RIGHT, OP_DOWN, OP_UP1, OP_UP2, OP_UPR, OP_WALK
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [CW-1:0] before_q, before_d, after_q, after_d;
  logic [CW-1:0] col_q, col_d, rem_q, rem_d;
  logic [CW-1:0] scan_k_q, scan_k_d, scan_n_q, scan_n_d;
  logic [LW-1:0] line_q, line_d, lines_q, lines_d;
  logic          saved_q, saved_d;
  logic [7:0]    res_char_q, res_char_d;
  logic          res_done_q, res_done_d, res_full_q, res_full_d;
  logic          m_valid_q, m_valid_d;
  logic [55:0]   m_data_q, m_data_d;

  // Text store: one write and one registered read per cycle.
  logic [7:0]    mem_q [CAPACITY];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic [CW-1:0] before_m1, top_rd, top_wr, scan_m1;
  logic [CW:0]   total;
  logic [2:0]    in_cmd;
  logic [7:0]    in_char;
  logic          nl, step_l, step_r;
  logic [31:0]   line_w, col_w, lines_w, len_w;

  assign before_m1 = before_q - CW'(1);
  assign top_rd    = CAPW - after_q;
  assign top_wr    = CAPW - after_q - CW'(1);
  assign scan_m1   = scan_k_q - CW'(1);
  assign total     = {1'b0, before_q} + {1'b0, after_q};
  assign in_cmd    = s_axis_tdata_i[2:0];
  assign in_char   = s_axis_tdata_i[10:3];
  assign nl        = (rdata_q == NEWLINE);

  assign line_w  = 32'(line_q);
  assign col_w   = 32'(col_q);
  assign lines_w = 32'(lines_q);
  assign len_w   = 32'(total);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Read address: the byte before the gap for leftward steps, the byte after
  // it for rightward steps, or the scan pointer when finding a column.
  always_comb begin
    raddr = '0;
    case (state_q)
      S_ISSUE: begin
        if (op_q == OP_BS || op_q == OP_LEFT || op_q == OP_UP1 || op_q == OP_UP2) begin
          raddr = before_m1[AW-1:0];
        end else begin
          raddr = top_rd[AW-1:0];
        end
      end
      S_SCAN:  raddr = scan_m1[AW-1:0];
      default: raddr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    before_d   = before_q;
    after_d    = after_q;
    col_d      = col_q;
    rem_d      = rem_q;
    scan_k_d   = scan_k_q;
    scan_n_d   = scan_n_q;
    line_d     = line_q;
    lines_d    = lines_q;
    saved_d    = saved_q;
    res_char_d = res_char_q;
    res_done_d = res_done_q;
    res_full_d = res_full_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    we         = 1'b0;
    waddr      = before_q[AW-1:0];
    wdata      = in_char;
    step_l     = 1'b0;
    step_r     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_char_d = '0;
          res_done_d = 1'b0;
          res_full_d = 1'b0;
          state_d    = S_DONE;
          case (cmd_e'(in_cmd))
            CMD_INSERT: begin
              if (total >= {1'b0, CAPW}) begin
                res_full_d = 1'b1;
              end else begin
                we         = 1'b1;
                before_d   = before_q + CW'(1);
                saved_d    = 1'b0;
                res_char_d = in_char;
                res_done_d = 1'b1;
                if (in_char == NEWLINE) begin
                  lines_d = lines_q + LW'(1);
                  line_d  = line_q + LW'(1);
                  col_d   = '0;
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
            end
            CMD_BACKSPACE: begin
              if (before_q != '0) begin
                op_d = OP_BS; state_d = S_ISSUE;
              end
            end
            CMD_LEFT: begin
              if (before_q != '0) begin
                op_d = OP_LEFT; state_d = S_ISSUE;
              end
            end
            CMD_RIGHT: begin
              if (after_q != '0) begin
                op_d = OP_RIGHT; state_d = S_ISSUE;
              end
            end
            CMD_DOWN: begin
              if (line_q < lines_q) begin
                res_done_d = 1'b1;
                rem_d      = col_q;
                op_d       = OP_DOWN;
                state_d    = S_ISSUE;
              end
            end
            CMD_UP: begin
              if (line_q > LW'(1)) begin
                res_done_d = 1'b1;
                rem_d      = col_q;
                op_d       = OP_UP1;
                state_d    = S_ISSUE;
              end
            end
            CMD_CLEAR: begin
              if (total != '0) begin
                saved_d = 1'b0;
              end
              before_d   = '0;
              after_d    = '0;
              line_d     = LW'(1);
              col_d      = '0;
              lines_d    = LW'(1);
              res_done_d = 1'b1;
            end
            default: begin
              saved_d    = 1'b1;
              res_done_d = 1'b1;
            end
          endcase
        end
      end

      S_ISSUE: state_d = S_EXEC;

      S_EXEC: begin
        state_d = S_ISSUE;
        case (op_q)
          OP_BS: begin
            before_d   = before_m1;
            saved_d    = 1'b0;
            res_char_d = rdata_q;
            res_done_d = 1'b1;
            if (nl) begin
              lines_d  = lines_q - LW'(1);
              line_d   = line_q - LW'(1);
              scan_k_d = before_m1;
              scan_n_d = '0;
              col_d    = '0;
              state_d  = (before_m1 == '0) ? S_DONE : S_SCAN;
            end else begin
              col_d   = col_q - CW'(1);
              state_d = S_DONE;
            end
          end
          OP_LEFT: begin
            step_l     = 1'b1;
            res_char_d = rdata_q;
            res_done_d = 1'b1;
            if (nl) begin
              scan_k_d = before_m1;
              scan_n_d = '0;
              col_d    = '0;
              state_d  = (before_m1 == '0) ? S_DONE : S_SCAN;
            end else begin
              col_d   = col_q - CW'(1);
              state_d = S_DONE;
            end
          end
          OP_RIGHT: begin
            step_r     = 1'b1;
            res_char_d = rdata_q;
            res_done_d = 1'b1;
            col_d      = nl ? '0 : col_q + CW'(1);
            state_d    = S_DONE;
          end
          OP_DOWN: begin
            step_r = 1'b1;
            if (nl) begin
              col_d   = '0;
              state_d = S_WALK;
            end else if (after_q == CW'(1)) begin
              state_d = S_DONE;
            end
          end
          OP_UP1: begin
            step_l = 1'b1;
            if (before_q == CW'(1)) begin
              col_d   = '0;
              state_d = S_WALK;
            end else if (nl) begin
              op_d = OP_UP2;
            end
          end
          OP_UP2: begin
            step_l = 1'b1;
            if (nl) begin
              op_d = OP_UPR;
            end else if (before_q == CW'(1)) begin
              col_d   = '0;
              state_d = S_WALK;
            end
          end
          OP_UPR: begin
            step_r  = 1'b1;
            col_d   = '0;
            state_d = S_WALK;
          end
          default: begin
            // Walk along the target line; stop in front of its newline.
            if (nl) begin
              state_d = S_DONE;
            end else begin
              step_r  = 1'b1;
              col_d   = col_q + CW'(1);
              rem_d   = rem_q - CW'(1);
              state_d = S_WALK;
            end
          end
        endcase
      end

      S_WALK: begin
        if (rem_q == '0 || after_q == '0) begin
          state_d = S_DONE;
        end else begin
          op_d    = OP_WALK;
          state_d = S_ISSUE;
        end
      end

      S_SCAN: state_d = S_SCEX;

      S_SCEX: begin
        if (nl) begin
          col_d   = scan_n_q;
          state_d = S_DONE;
        end else begin
          scan_n_d = scan_n_q + CW'(1);
          scan_k_d = scan_m1;
          if (scan_k_q == CW'(1)) begin
            col_d   = scan_n_q + CW'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, saved_q, len_w[10:0], lines_w[10:0], col_w[10:0],
                       line_w[10:0], res_full_q, res_done_q, res_char_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // One byte moved across the gap, leftwards or rightwards.
    if (step_l) begin
      we       = 1'b1;
      waddr    = top_wr[AW-1:0];
      wdata    = rdata_q;
      before_d = before_m1;
      after_d  = after_q + CW'(1);
      if (nl) begin
        line_d = line_q - LW'(1);
      end
    end
    if (step_r) begin
      we       = 1'b1;
      waddr    = before_q[AW-1:0];
      wdata    = rdata_q;
      before_d = before_q + CW'(1);
      after_d  = after_q - CW'(1);
      if (nl) begin
        line_d = line_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_BS;
      before_q   <= '0;
      after_q    <= '0;
      col_q      <= '0;
      rem_q      <= '0;
      scan_k_q   <= '0;
      scan_n_q   <= '0;
      line_q     <= LW'(1);
      lines_q    <= LW'(1);
      saved_q    <= 1'b1;
      res_char_q <= '0;
      res_done_q <= 1'b0;
      res_full_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      before_q   <= before_d;
      after_q    <= after_d;
      col_q      <= col_d;
      rem_q      <= rem_d;
      scan_k_q   <= scan_k_d;
      scan_n_q   <= scan_n_d;
      line_q     <= line_d;
      lines_q    <= lines_d;
      saved_q    <= saved_d;
      res_char_q <= res_char_d;
      res_done_q <= res_done_d;
      res_full_q <= res_full_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= {1'b0, CAPW}) else $error("text exceeds store capacity");
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (line_q >= LW'(1) && line_q <= lines_q))
    else $error("cursor line outside the text");
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (col_q <= before_q))
    else $error("cursor column beyond bytes before the gap");
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result shown without a finished request");
`endif

endmodule
`default_nettype wire

/* sim/gap_buffer_cursor_engine_unit_tb.sv */
// Self-checking testbench for the gap buffer cursor engine: a directed table
// of edits and cursor moves, then random editing traffic, checked by a model.
// Depends on gbce_pkg and gap_buffer_cursor_engine_unit.
`timescale 1ns / 1ps
module gap_buffer_cursor_engine_unit_tb;
  import gbce_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  // Result layout as it leaves the block, the highest field first.
  typedef struct packed {
    logic        pad;
    logic        saved;
    logic [10:0] len;
    logic [10:0] lines;
    logic [10:0] col;
    logic [10:0] line;
    logic        full;
    logic        done;
    logic [7:0]  ch;
  } edit_res_t;

  // One row of the directed table. Where has_typed is set, the character,
  // done and full fields are taken from the row rather than from the model.
  typedef struct {
    cmd_e       cmd;
    logic [7:0] ch;
    bit         has_typed;
    logic [7:0] t_ch;
    logic       t_done;
    logic       t_full;
  } edit_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // Fields from bit 0: cmd[2:0], char_in[10:3], zeros above.
  logic [15:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // Fields from bit 0: char_out, done_res, full_res, cursor_line, cursor_col,
  // line_count, text_length, is_saved, zeros above.
  logic [55:0] m_axis_tdata_o;

  gap_buffer_cursor_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Shadow copy of the text and cursor state.
  logic [7:0]  txt [CAP];
  int unsigned pre_n, post_n, cur_line, cur_col, n_lines;
  bit          is_clean;

  edit_res_t   pending_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Column of the cursor: bytes back to the previous newline.
  function automatic int unsigned col_at_cursor();
    int unsigned k;
    int unsigned n;
    k = pre_n;
    n = 0;
    while (k > 0 && txt[k-1] != NEWLINE) begin
      k--;
      n++;
    end
    return n;
  endfunction

  function automatic int move_left();
    logic [7:0] b;
    if (pre_n == 0) return -1;
    b = txt[pre_n-1];
    pre_n--;
    post_n++;
    txt[CAP-post_n] = b;
    if (b == NEWLINE) begin
      cur_line--;
      cur_col = col_at_cursor();
    end else begin
      cur_col--;
    end
    return int'(b);
  endfunction

  function automatic int move_right();
    logic [7:0] b;
    if (post_n == 0) return -1;
    b = txt[CAP-post_n];
    post_n--;
    txt[pre_n] = b;
    pre_n++;
    if (b == NEWLINE) begin
      cur_line++;
      cur_col = 0;
    end else begin
      cur_col++;
    end
    return int'(b);
  endfunction

  // From the start of a line, go right up to want bytes but stay on it.
  function automatic void seek_col(int unsigned want);
    int r;
    for (int unsigned i = 0; i < want; i++) begin
      r = move_right();
      if (r < 0) break;
      if (r == int'(NEWLINE)) begin
        void'(move_left());
        break;
      end
    end
  endfunction

  function automatic edit_res_t apply_edit(cmd_e cmd, logic [7:0] ch);
    edit_res_t   res;
    int          r;
    int unsigned keep;
    logic [7:0]  g;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (pre_n + post_n >= CAP) begin
          res.full = 1'b1;
        end else begin
          txt[pre_n] = ch;
          pre_n++;
          is_clean = 1'b0;
          if (ch == NEWLINE) begin
            n_lines++;
            cur_line++;
            cur_col = 0;
          end else begin
            cur_col++;
          end
          res.ch   = ch;
          res.done = 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        if (pre_n > 0) begin
          g = txt[pre_n-1];
          pre_n--;
          is_clean = 1'b0;
          if (g == NEWLINE) begin
            n_lines--;
            cur_line--;
            cur_col = col_at_cursor();
          end else begin
            cur_col--;
          end
          res.ch   = g;
          res.done = 1'b1;
        end
      end
      CMD_LEFT, CMD_RIGHT: begin
        r = (cmd == CMD_LEFT) ? move_left() : move_right();
        if (r >= 0) begin
          res.ch   = r[7:0];
          res.done = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (cur_line < n_lines) begin
          keep = cur_col;
          do r = move_right(); while (r >= 0 && r != int'(NEWLINE));
          seek_col(keep);
          res.done = 1'b1;
        end
      end
      CMD_UP: begin
        if (cur_line > 1) begin
          keep = cur_col;
          do r = move_left(); while (r >= 0 && r != int'(NEWLINE));
          do r = move_left(); while (r >= 0 && r != int'(NEWLINE));
          if (r >= 0) void'(move_right());
          seek_col(keep);
          res.done = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (pre_n + post_n > 0) is_clean = 1'b0;
        pre_n    = 0;
        post_n   = 0;
        cur_line = 1;
        cur_col  = 0;
        n_lines  = 1;
        res.done = 1'b1;
      end
      default: begin
        is_clean = 1'b1;
        res.done = 1'b1;
      end
    endcase
    res.line  = cur_line[10:0];
    res.col   = cur_col[10:0];
    res.lines = n_lines[10:0];
    res.len   = 11'(pre_n + post_n);
    res.saved = is_clean;
    return res;
  endfunction

  // Drive one request and wait for it to be taken; the expectation is
  // queued at the accepting edge.
  task automatic send_edit(cmd_e cmd, logic [7:0] ch, bit has_typed,
                           logic [7:0] t_ch, logic t_done, logic t_full);
    edit_res_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {5'd0, ch, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = apply_edit(cmd, ch);
    if (has_typed) begin
      res.ch   = t_ch;
      res.done = t_done;
      res.full = t_full;
    end
    pending_q.push_back(res);
  endtask

  function automatic logic [7:0] rand_char();
    return ($urandom_range(0, 5) == 0) ? NEWLINE : 8'($urandom_range(0, 255));
  endfunction

  // Random command; ins_pct is the share of inserts, the rest spread over
  // the other commands with clear kept rare, and only when allow_clear is set.
  function automatic cmd_e rand_cmd(int unsigned ins_pct, bit allow_clear);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < ins_pct) return CMD_INSERT;
    p = $urandom_range(0, 99);
    if (p < 3) return allow_clear ? CMD_CLEAR : CMD_MARK;
    if (p < 8) return CMD_MARK;
    return cmd_e'(3'($urandom_range(1, 5)));
  endfunction

  // Output side: random stall bursts, none once the run goes quiet.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
    end
  end

  task automatic check_field(string name, logic [10:0] want, logic [10:0] got,
                             inout bit bad);
    if (want !== got) begin
      if (!bad && mismatches < 10)
        $display("mismatch at cycle %0d:", cycles);
      if (mismatches < 10)
        $display("  %s expected %0d got %0d", name, want, got);
      bad = 1'b1;
    end
  endtask

  // Result checker: every result taken is matched against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    edit_res_t want;
    edit_res_t got;
    bit        bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = edit_res_t'(m_axis_tdata_o);
      bad = 1'b0;
      if (pending_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        check_field("char_out", 11'(want.ch), 11'(got.ch), bad);
        check_field("done_res", 11'(want.done), 11'(got.done), bad);
        check_field("full_res", 11'(want.full), 11'(got.full), bad);
        check_field("cursor_line", want.line, got.line, bad);
        check_field("cursor_col", want.col, got.col, bad);
        check_field("line_count", want.lines, got.lines, bad);
        check_field("text_length", want.len, got.len, bad);
        check_field("is_saved", 11'(want.saved), 11'(got.saved), bad);
        if (bad) mismatches++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gap_buffer_cursor_engine_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    edit_row_t rows[$];
    int unsigned ins_pct;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cycles          = 0;
    mismatches      = 0;
    quiet           = 1'b0;
    pre_n           = 0;
    post_n          = 0;
    cur_line        = 1;
    cur_col         = 0;
    n_lines         = 1;
    is_clean        = 1'b1;
    foreach (txt[i]) txt[i] = 8'd0;

    // Empty text: nothing to cross and no line to move to, then edits.
    rows = '{
      '{CMD_BACKSPACE, 8'h00, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_LEFT,      8'h00, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_RIGHT,     8'hFF, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_UP,        8'h00, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_DOWN,      8'h00, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_CLEAR,     8'h00, 1, 8'h00, 1'b1, 1'b0},
      '{CMD_MARK,      8'h00, 1, 8'h00, 1'b1, 1'b0},
      '{CMD_INSERT,    8'h41, 1, 8'h41, 1'b1, 1'b0},
      '{CMD_INSERT,    8'hFF, 1, 8'hFF, 1'b1, 1'b0},
      '{CMD_INSERT,    8'h00, 1, 8'h00, 1'b1, 1'b0},
      '{CMD_INSERT,    NEWLINE, 1, NEWLINE, 1'b1, 1'b0},
      '{CMD_INSERT,    8'h62, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_INSERT,    NEWLINE, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_DOWN,      8'h00, 1, 8'h00, 1'b0, 1'b0},
      '{CMD_UP,        8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_UP,        8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_RIGHT,     8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_DOWN,      8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_LEFT,      8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_BACKSPACE, 8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_BACKSPACE, 8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_MARK,      8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_CLEAR,     8'h00, 0, 8'h00, 1'b0, 1'b0},
      '{CMD_CLEAR,     8'h00, 0, 8'h00, 1'b0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i])
      send_edit(rows[i].cmd, rows[i].ch, rows[i].has_typed,
                rows[i].t_ch, rows[i].t_done, rows[i].t_full);

    // Fill phase: mostly inserts and no clear, so the store runs full and
    // keeps refusing inserts for a while amid moves and edits.
    for (int i = 0; i < 1300; i++)
      send_edit(rand_cmd(90, 1'b0), rand_char(), 1'b0, 8'h00, 1'b0, 1'b0);

    // Mixed phase, the tail of it without idling on either side.
    for (int i = 0; i < 350; i++) begin
      if (i == 200) quiet = 1'b1;
      ins_pct = (i % 100 < 50) ? 60 : 30;
      send_edit(rand_cmd(ins_pct, 1'b1), rand_char(), 1'b0, 8'h00, 1'b0, 1'b0);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gap_buffer_cursor_engine_unit_tb: PASS");
    end else begin
      $display("gap_buffer_cursor_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gbce_pkg.sv
rtl/core/gap_buffer_cursor_engine_unit.sv
sim/gap_buffer_cursor_engine_unit_tb.sv
